[rtl/timer_string_to_bcd_parser_unit_assert.svh]
// ----------------------------------------------------------------------------
// timer string parser assertion macros
// shared assertion wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef TIMER_STRING_TO_BCD_PARSER_UNIT_ASSERT_SVH
`define TIMER_STRING_TO_BCD_PARSER_UNIT_ASSERT_SVH

// property checked outside of reset
`define TSBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define TSBP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tsbp_pkg.sv]
// ----------------------------------------------------------------------------
// tsbp_pkg
// shared constants, types and character helpers of the timer string parser
// ----------------------------------------------------------------------------
package tsbp_pkg;

	localparam int MAX_BYTES   = 28;
	localparam int STAMP_BYTES = 4;
	localparam int MAX_RESULTS = STAMP_BYTES + 1;
	localparam int IDX_W       = 5;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int SLOT_W      = $clog2(MAX_RESULTS);

	localparam logic [IDX_W-1:0] LEN_RESET = IDX_W'(MAX_BYTES);

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [7:0] OFF_EVEN = 8'hff;
	localparam logic [7:0] OFF_ODD  = 8'h0f;

	// class of the first character of a pair: 0..9 digit, then these
	localparam logic [3:0] CLS_BLANK = 4'd10;
	localparam logic [3:0] CLS_PLUS  = 4'd11;
	localparam logic [3:0] CLS_OTHER = 4'd12;
	localparam logic [3:0] CLS_DIGIT_MAX = 4'd9;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [7:0]       value;
		logic             is_status;
		logic             ok;
	} result_t;

	typedef struct packed {
		result_t [MAX_RESULTS-1:0] res;
		logic [CNT_W-1:0]          cnt;
	} burst_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic [3:0] classify(input logic [7:0] c);
		logic [3:0] cls;
		if (is_digit(c)) cls = c[3:0];
		else if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) cls = CLS_BLANK;
		else if (c == CHAR_PLUS) cls = CLS_PLUS;
		else cls = CLS_OTHER;
		return cls;
	endfunction

	// atoi value of a pair, straight in bcd
	function automatic logic [7:0] pair_bcd(input logic [3:0] first, input logic [7:0] c);
		logic [7:0] v;
		if (first <= CLS_DIGIT_MAX) v = is_digit(c) ? {first, c[3:0]} : {4'h0, first};
		else if (first == CLS_BLANK || first == CLS_PLUS) v = is_digit(c) ? {4'h0, c[3:0]} : 8'h00;
		else v = 8'h00;
		return v;
	endfunction

	function automatic logic [7:0] off_byte(input logic odd);
		return odd ? OFF_ODD : OFF_EVEN;
	endfunction

endpackage

[rtl/tsbp_core.sv]
// ----------------------------------------------------------------------------
// tsbp_core
// input register, length register, parse state and one-pass evaluation
// ----------------------------------------------------------------------------
module tsbp_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             text_char,
	input  logic                   last,
	input  logic                   length_we,
	input  logic [tsbp_pkg::IDX_W-1:0] length_wdata,
	input  logic                   can_load,
	output logic                   burst_ld,
	output tsbp_pkg::burst_t       burst
);
	import tsbp_pkg::*;

	typedef enum logic [1:0] {PH_H1, PH_H2, PH_M1, PH_M2} phase_t;

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;

	logic [IDX_W-1:0] length_q;
	logic [IDX_W-1:0] wi_q, wi_n;
	phase_t           phase_q, phase_n;
	logic [7:0]       hour_q, hour_n;
	logic [3:0]       part_q, part_n;
	logic             err_q, err_n;
	logic             stop_q, stop_n;
	logic [7:0]       hist_q [STAMP_BYTES];
	logic [7:0]       hist_n [STAMP_BYTES];

	logic [IDX_W:0]   len6;
	logic [IDX_W:0]   wi6;
	logic [SLOT_W-1:0] nbytes;
	logic             fin_err;

	assign in_stall = valid_s1 && !can_load;
	assign burst_ld = valid_s1 && can_load;

	assign len6 = (length_q > LEN_RESET) ? (IDX_W+1)'(MAX_BYTES) : {1'b0, length_q};
	assign wi6  = {1'b0, wi_q};

	always_comb begin
		burst   = '0;
		nbytes  = '0;
		wi_n    = wi_q;
		phase_n = phase_q;
		hour_n  = hour_q;
		part_n  = part_q;
		err_n   = err_q;
		stop_n  = stop_q;
		fin_err = 1'b0;
		for (int k = 0; k < STAMP_BYTES; k++) hist_n[k] = hist_q[k];

		if (!err_q && !stop_q) begin
			case (phase_q)
				PH_H1: begin
					if (char_s1 == CHAR_NUL || wi6 >= len6) begin
						stop_n = 1'b1;
					end else if (char_s1 == CHAR_MINUS) begin
						burst.res[0].idx   = wi_q;
						burst.res[0].value = off_byte(wi_q[0]);
						if (wi6 + 1'b1 >= len6) begin
							nbytes = SLOT_W'(1);
							err_n  = 1'b1;
						end else begin
							burst.res[1].idx   = wi_q + 1'b1;
							burst.res[1].value = off_byte(!wi_q[0]);
							nbytes = SLOT_W'(2);
							wi_n   = wi_q + IDX_W'(2);
						end
					end else if (char_s1 == CHAR_PLUS) begin
						if (wi6 < (IDX_W+1)'(STAMP_BYTES)
							|| wi6 + (IDX_W+1)'(STAMP_BYTES) > len6) begin
							err_n = 1'b1;
						end else begin
							for (int k = 0; k < STAMP_BYTES; k++) begin
								burst.res[k].idx   = wi_q + IDX_W'(k);
								burst.res[k].value = hist_q[k];
							end
							nbytes = SLOT_W'(STAMP_BYTES);
							wi_n   = wi_q + IDX_W'(STAMP_BYTES);
						end
					end else if (wi6 + 1'b1 >= len6) begin
						err_n = 1'b1;
					end else begin
						part_n  = classify(char_s1);
						phase_n = PH_H2;
					end
				end
				PH_H2: begin
					if (char_s1 == CHAR_NUL) begin
						err_n = 1'b1;
					end else begin
						hour_n  = pair_bcd(part_q, char_s1);
						phase_n = PH_M1;
					end
				end
				PH_M1: begin
					if (char_s1 == CHAR_NUL) begin
						err_n = 1'b1;
					end else begin
						part_n  = classify(char_s1);
						phase_n = PH_M2;
					end
				end
				PH_M2: begin
					if (char_s1 == CHAR_NUL) begin
						err_n = 1'b1;
					end else begin
						// minutes first, hours after
						burst.res[0].idx   = wi_q;
						burst.res[0].value = pair_bcd(part_q, char_s1);
						burst.res[1].idx   = wi_q + 1'b1;
						burst.res[1].value = hour_q;
						nbytes  = SLOT_W'(2);
						wi_n    = wi_q + IDX_W'(2);
						phase_n = PH_H1;
					end
				end
				default: begin
					err_n = 1'b1;
				end
			endcase
		end

		// written bytes enter the stamp history in order
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (SLOT_W'(k) < nbytes) begin
				for (int j = 0; j < STAMP_BYTES - 1; j++) hist_n[j] = hist_n[j+1];
				hist_n[STAMP_BYTES-1] = burst.res[k].value;
			end
		end

		burst.cnt = CNT_W'(nbytes);
		if (last_s1) begin
			fin_err = err_n || (phase_n != PH_H1);
			burst.res[nbytes].idx       = '0;
			burst.res[nbytes].value     = '0;
			burst.res[nbytes].is_status = 1'b1;
			burst.res[nbytes].ok        = !fin_err && ({1'b0, wi_n} == len6);
			burst.cnt = CNT_W'(nbytes) + 1'b1;
			wi_n    = '0;
			phase_n = PH_H1;
			hour_n  = '0;
			part_n  = '0;
			err_n   = 1'b0;
			stop_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			length_q <= LEN_RESET;
			wi_q     <= '0;
			phase_q  <= PH_H1;
			hour_q   <= '0;
			part_q   <= '0;
			err_q    <= 1'b0;
			stop_q   <= 1'b0;
		end else begin
			if (length_we) length_q <= length_wdata;
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (burst_ld) begin
				valid_s1 <= 1'b0;
			end
			if (burst_ld) begin
				wi_q    <= wi_n;
				phase_q <= phase_n;
				hour_q  <= hour_n;
				part_q  <= part_n;
				err_q   <= err_n;
				stop_q  <= stop_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= text_char;
			last_s1 <= last;
		end
		if (burst_ld) begin
			for (int k = 0; k < STAMP_BYTES; k++) hist_q[k] <= hist_n[k];
		end
	end

endmodule

[rtl/tsbp_burst.sv]
// ----------------------------------------------------------------------------
// tsbp_burst
// result buffer, sends the results of one item one per cycle unless out_stall is high
// ----------------------------------------------------------------------------
module tsbp_burst (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   burst_ld,
	input  tsbp_pkg::burst_t       burst,
	output logic                   can_load,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [tsbp_pkg::IDX_W-1:0] byte_index,
	output logic [7:0]             byte_value,
	output logic                   is_status,
	output logic                   ok,
	output logic                   run_end
);
	import tsbp_pkg::*;

	result_t          res_s2 [MAX_RESULTS];
	logic [CNT_W-1:0] cnt_s2;

	assign out_valid  = (cnt_s2 != '0);
	assign can_load   = (cnt_s2 == '0) || (cnt_s2 == CNT_W'(1) && !out_stall);
	assign byte_index = res_s2[0].idx;
	assign byte_value = res_s2[0].value;
	assign is_status  = res_s2[0].is_status;
	assign ok         = res_s2[0].ok;
	assign run_end    = (cnt_s2 == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (burst_ld) begin
			cnt_s2 <= burst.cnt;
		end else if (out_valid && !out_stall) begin
			cnt_s2 <= cnt_s2 - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (burst_ld) begin
			for (int k = 0; k < MAX_RESULTS; k++) res_s2[k] <= burst.res[k];
		end else if (out_valid && !out_stall) begin
			for (int k = 0; k < MAX_RESULTS - 1; k++) res_s2[k] <= res_s2[k+1];
		end
	end

endmodule

[rtl/timer_string_to_bcd_parser_unit.sv]
// ----------------------------------------------------------------------------
// timer_string_to_bcd_parser_unit
// turns a timer text, one character per transaction, into bcd timer bytes
// ----------------------------------------------------------------------------
// Each accepted character is held in an input register and evaluated in one
// pass against the parse state; the bytes it writes (none, one, two, or four
// for '+') plus a status result after the character marked last are loaded
// together into a result buffer, which sends one result per cycle unless
// out_stall is high. A character with at most one result lets the next one
// follow right behind; with more (at most five, '+' with last) it holds the
// buffer and the input side until its last result is sent. Each character
// passes the input register, then the result buffer. The length register
// (reset 28, values above 28 act as 28) is for the user to write only while
// the unit is idle; the unit does not enforce this. The last four bytes
// written are kept for '+', which only copies bytes the string wrote itself.
module timer_string_to_bcd_parser_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	// character transaction
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             text_char,
	input  logic                   last,
	// length register write
	input  logic                   length_we,
	input  logic [tsbp_pkg::IDX_W-1:0] length_wdata,
	// result transaction
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [tsbp_pkg::IDX_W-1:0] byte_index,
	output logic [7:0]             byte_value,
	output logic                   is_status,
	output logic                   ok,
	output logic                   run_end
);
	import tsbp_pkg::*;

	burst_t burst;
	logic   burst_ld;
	logic   can_load;

	// parse state and single-pass evaluation
	tsbp_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_char    (text_char),
		.last         (last),
		.length_we    (length_we),
		.length_wdata (length_wdata),
		.can_load     (can_load),
		.burst_ld     (burst_ld),
		.burst        (burst)
	);

	// result buffer, drains one result per cycle unless out_stall is high
	tsbp_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.burst_ld   (burst_ld),
		.burst      (burst),
		.can_load   (can_load),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.byte_index (byte_index),
		.byte_value (byte_value),
		.is_status  (is_status),
		.ok         (ok),
		.run_end    (run_end)
	);

endmodule

[rtl/tsbp_checker.sv]
// ----------------------------------------------------------------------------
// tsbp_checker
// port checks of the timer string parser, bound to the top level
// ----------------------------------------------------------------------------
`include "timer_string_to_bcd_parser_unit_assert.svh"

module tsbp_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic [tsbp_pkg::IDX_W-1:0] byte_index,
	input logic [7:0]             byte_value,
	input logic                   is_status,
	input logic                   ok,
	input logic                   run_end
);
	import tsbp_pkg::*;

	// the status always closes the results of its transaction
	`TSBP_ASSERT(a_status_ends_run, out_valid && is_status |-> run_end, "status not at run end")
	// a status carries no byte
	`TSBP_ASSERT(a_status_empty, out_valid && is_status |-> byte_index == '0 && byte_value == '0, "status carries a byte")
	// byte results carry no ok and stay inside the byte range
	`TSBP_ASSERT(a_byte_range, out_valid && !is_status |-> !ok && byte_index < IDX_W'(MAX_BYTES), "bad byte result")
	// nothing leaves while reset is held
	`TSBP_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result during reset")

endmodule

bind timer_string_to_bcd_parser_unit tsbp_checker u_tsbp_checker (.*);
